>>> rtl/acq_pkg.sv
// acq_pkg: shared field widths, command codes and register indexes
// for the alarm counter queue. No dependencies.
package acq_pkg;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATE       = 1'd1;

endpackage

>>> rtl/acq_if.sv
// acq_if: valid/ready channels of the alarm counter queue (command,
// expiry report, register write). Depends on acq_pkg.
interface acq_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [acq_pkg::CMD_W-1:0]      cmd;
    logic [acq_pkg::SLOT_W-1:0]     alarm_slot;
    logic [acq_pkg::FIELD_W-1:0]    alarm_date;
    logic [acq_pkg::FIELD_W-1:0]    alarm_cycle;

    modport source (output valid, cmd, alarm_slot, alarm_date, alarm_cycle, input ready);
    modport sink   (input valid, cmd, alarm_slot, alarm_date, alarm_cycle, output ready);
endinterface

interface acq_res_if;
    logic                           valid;
    logic                           ready;
    logic [acq_pkg::SLOT_W-1:0]     expired_slot;
    logic                           rearmed;
    logic                           last_of_tick;

    modport source (output valid, expired_slot, rearmed, last_of_tick, input ready);
    modport sink   (input valid, expired_slot, rearmed, last_of_tick, output ready);
endinterface

interface acq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [acq_pkg::CFG_IDX_W-1:0]  index;
    logic [acq_pkg::FIELD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/alarm_counter_queue.sv
// alarm_counter_queue: prescaled wrapping date counter with alarm slots kept
// in a one-port-read synchronous memory. Depends on acq_pkg and acq_if.
// Arm, cancel and a tick that does not advance the date are handled in idle.
// A date-advancing tick scans min(NUM_ALARMS,16) slots (one memory read per
// slot), emits each expiry and computes each cyclic re-arm date by a
// bit-serial modulo; output backpressure can stall it.
// One command at a time; reset clears date, prescaler and active flags,
// slot memory stays undefined and needs no clearing pass.
module alarm_counter_queue #(
    parameter int NUM_ALARMS = 16,
    parameter int DATE_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    acq_cmd_if.sink   req,
    acq_res_if.source res,
    acq_cfg_if.sink   cfg
);
    import acq_pkg::*;

    localparam int DEPTH = (NUM_ALARMS < 16) ? NUM_ALARMS : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (DATE_BITS > FIELD_W) ? DATE_BITS : FIELD_W;
    localparam int SW    = CW + 1;
    localparam int NW    = $clog2(SW + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef struct packed {
        logic [FIELD_W-1:0]   cycle;
        logic [DATE_BITS-1:0] date;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_MOD,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;
    slot_entry_t mem_wdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;

    state_t                state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [FIELD_W-1:0]    prescale_reg, prescale_next;
    logic [DATE_BITS-1:0]  cur_date_reg, cur_date_next;
    logic [FIELD_W-1:0]    tpb_reg, tpb_next;
    logic [FIELD_W-1:0]    max_reg, max_next;
    logic [DEPTH-1:0]      active_reg, active_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [AW-1:0]         pend_slot_reg, pend_slot_next;
    logic                  pend_rearm_reg, pend_rearm_next;
    logic                  hit_rearm_reg, hit_rearm_next;
    logic                  out_valid_reg, out_valid_next;
    logic [AW-1:0]         out_slot_reg, out_slot_next;
    logic                  out_rearm_reg, out_rearm_next;
    logic                  out_last_reg, out_last_next;
    logic [SW-1:0]         div_sum_reg, div_sum_next;
    logic [FIELD_W-1:0]    div_rem_reg, div_rem_next;
    logic [NW-1:0]         div_cnt_reg, div_cnt_next;

    logic                  out_free;
    logic                  slot_ok;
    logic                  hit;
    logic [FIELD_W:0]      modulus;
    logic [FIELD_W:0]      trial;
    logic [FIELD_W-1:0]    step_rem;

    assign req.ready        = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign res.valid        = out_valid_reg;
    assign res.expired_slot = SLOT_W'(out_slot_reg);
    assign res.rearmed      = out_rearm_reg;
    assign res.last_of_tick = out_last_reg;

    assign out_free = !out_valid_reg || res.ready;
    assign slot_ok  = ({1'b0, req.alarm_slot} < (SLOT_W + 1)'(DEPTH));
    assign hit      = active_reg[idx_reg] && (rd_data_reg.date == cur_date_reg);
    assign modulus  = {1'b0, max_reg} + (FIELD_W + 1)'(1);

    always_comb
    begin
        trial = {div_rem_reg, div_sum_reg[SW-1]};
        if (trial >= modulus)
        begin
            trial = trial - modulus;
        end
        step_rem = trial[FIELD_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        prescale_next   = prescale_reg;
        cur_date_next   = cur_date_reg;
        tpb_next        = tpb_reg;
        max_next        = max_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_rearm_next = pend_rearm_reg;
        hit_rearm_next  = hit_rearm_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_slot_next   = out_slot_reg;
        out_rearm_next  = out_rearm_reg;
        out_last_next   = out_last_reg;
        div_sum_next    = div_sum_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        rd_addr         = idx_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICKS_PER_BASE: tpb_next = cfg.data;
                CFG_MAX_DATE:       max_next = cfg.data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd)
                        CMD_TICK:
                        begin
                            if (({1'b0, prescale_reg} + (FIELD_W + 1)'(1)) >=
                                {1'b0, tpb_reg})
                            begin
                                prescale_next = '0;
                                if (CW'(cur_date_reg) >= CW'(max_reg))
                                begin
                                    cur_date_next = '0;
                                end
                                else
                                begin
                                    cur_date_next = cur_date_reg + DATE_BITS'(1);
                                end
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                            else
                            begin
                                prescale_next = prescale_reg + FIELD_W'(1);
                            end
                        end
                        CMD_ARM:
                        begin
                            if (slot_ok)
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = AW'(req.alarm_slot);
                                mem_wdata.date  = DATE_BITS'(req.alarm_date);
                                mem_wdata.cycle = req.alarm_cycle;
                                active_next[AW'(req.alarm_slot)] = 1'b1;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (slot_ok)
                            begin
                                active_next[AW'(req.alarm_slot)] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (hit)
                begin
                    if (rd_data_reg.cycle != '0)
                    begin
                        div_sum_next   = SW'(rd_data_reg.date) + SW'(rd_data_reg.cycle);
                        div_rem_next   = '0;
                        div_cnt_next   = NW'(SW);
                        hit_rearm_next = 1'b1;
                        state_next     = ST_MOD;
                    end
                    else
                    begin
                        active_next[idx_reg] = 1'b0;
                        hit_rearm_next       = 1'b0;
                        state_next           = ST_EMIT;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = idx_reg + AW'(1);
                end
            end
            ST_MOD:
            begin
                div_rem_next = step_rem;
                div_sum_next = {div_sum_reg[SW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - NW'(1);
                if (div_cnt_reg == NW'(1))
                begin
                    mem_we         = 1'b1;
                    mem_wdata.date = DATE_BITS'(step_rem);
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_slot_next  = pend_slot_reg;
                        out_rearm_next = pend_rearm_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = idx_reg;
                    pend_rearm_next = hit_rearm_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = pend_slot_reg;
                    out_rearm_next  = pend_rearm_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            prescale_reg   <= '0;
            cur_date_reg   <= '0;
            tpb_reg        <= FIELD_W'(1);
            max_reg        <= '1;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_rearm_reg <= 1'b0;
            hit_rearm_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_rearm_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            div_sum_reg    <= '0;
            div_rem_reg    <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            prescale_reg   <= prescale_next;
            cur_date_reg   <= cur_date_next;
            tpb_reg        <= tpb_next;
            max_reg        <= max_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            pend_rearm_reg <= pend_rearm_next;
            hit_rearm_reg  <= hit_rearm_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_rearm_reg  <= out_rearm_next;
            out_last_reg   <= out_last_next;
            div_sum_reg    <= div_sum_next;
            div_rem_reg    <= div_rem_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !pend_valid_reg)
        else $error("pending expiry while accepting commands");

    a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOD |-> div_cnt_reg != '0)
        else $error("modulo step with exhausted count");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> ($past(state_reg) == ST_EMIT || $past(state_reg) == ST_FLUSH))
        else $error("expiry word raised outside emit or flush");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && pend_valid_reg && out_free)
            |=> (res.valid && res.last_of_tick && state_reg == ST_IDLE))
        else $error("final expiry of a tick not marked last");

endmodule
